### src/triangle_barycentric_coords_top_defines.svh
// Assertion helpers for the barycentric block.
`ifndef TRIANGLE_BARYCENTRIC_COORDS_TOP_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_TOP_DEFINES_SVH

// Implication checked on every clock, off while in reset.
`define TBC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold on every clock out of reset.
`define TBC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

### src/tbc_pkg.sv
`timescale 1ns / 1ps
package tbc_pkg;
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int W_BITS     = 24;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int MAG_W      = CROSS_W;
	localparam int QB         = W_BITS - 1;
	localparam int DW         = MAG_W + W_BITS;
	localparam int Q_DEPTH    = 8;
	localparam int Q_AW       = $clog2(Q_DEPTH);

	typedef struct packed {
		logic             deg;
		logic             in_tri;
		logic             neg1;
		logic             neg2;
		logic [MAG_W-1:0] num1;
		logic [MAG_W-1:0] num2;
		logic [MAG_W-1:0] den;
	} tbc_entry_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QB-1:0] quo;
		logic          sat;
		logic          neg;
	} div_lane_t;

	typedef struct packed {
		div_lane_t        l1;
		div_lane_t        l2;
		logic [MAG_W-1:0] den;
		logic             deg;
		logic             in_tri;
	} div_stage_t;

	function automatic logic [MAG_W-1:0] mag(input logic signed [CROSS_W-1:0] x);
		logic signed [CROSS_W-1:0] n;
		n = -x;
		return x[CROSS_W-1] ? MAG_W'(n) : MAG_W'(x);
	endfunction
endpackage

### src/tbc_front.sv
`timescale 1ns / 1ps
module tbc_front import tbc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic signed [COORD_BITS-1:0] vert0_x,
	input  logic signed [COORD_BITS-1:0] vert0_y,
	input  logic signed [COORD_BITS-1:0] vert1_x,
	input  logic signed [COORD_BITS-1:0] vert1_y,
	input  logic signed [COORD_BITS-1:0] vert2_x,
	input  logic signed [COORD_BITS-1:0] vert2_y,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	output logic                         push,
	output tbc_entry_t                   entry,
	output logic [1:0]                   inflight
);
	logic v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0] e1x_s1, e1y_s1, e2x_s1, e2y_s1, dx_s1, dy_s1;
	logic signed [PROD_W-1:0] a1_s2, a2_s2, b1_s2, b2_s2, d1_s2, d2_s2;
	logic signed [CROSS_W-1:0] area_s3, c1_s3, c2_s3;
	logic signed [CROSS_W+1:0] c0;
	logic in0, in1, in2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		e1x_s1 <= DIFF_W'(vert1_x) - DIFF_W'(vert0_x);
		e1y_s1 <= DIFF_W'(vert1_y) - DIFF_W'(vert0_y);
		e2x_s1 <= DIFF_W'(vert2_x) - DIFF_W'(vert0_x);
		e2y_s1 <= DIFF_W'(vert2_y) - DIFF_W'(vert0_y);
		dx_s1  <= DIFF_W'(query_x) - DIFF_W'(vert0_x);
		dy_s1  <= DIFF_W'(query_y) - DIFF_W'(vert0_y);
		a1_s2  <= e1x_s1 * e2y_s1;
		a2_s2  <= e1y_s1 * e2x_s1;
		b1_s2  <= dx_s1 * e2y_s1;
		b2_s2  <= dy_s1 * e2x_s1;
		d1_s2  <= e1x_s1 * dy_s1;
		d2_s2  <= e1y_s1 * dx_s1;
		area_s3 <= CROSS_W'(a1_s2) - CROSS_W'(a2_s2);
		c1_s3   <= CROSS_W'(b1_s2) - CROSS_W'(b2_s2);
		c2_s3   <= CROSS_W'(d1_s2) - CROSS_W'(d2_s2);
	end

	always_comb begin
		c0  = (CROSS_W+2)'(area_s3) - (CROSS_W+2)'(c1_s3) - (CROSS_W+2)'(c2_s3);
		in0 = (c0 != '0) && (c0[CROSS_W+1] == area_s3[CROSS_W-1]);
		in1 = (c1_s3 != '0) && (c1_s3[CROSS_W-1] == area_s3[CROSS_W-1]);
		in2 = (c2_s3 != '0) && (c2_s3[CROSS_W-1] == area_s3[CROSS_W-1]);
		entry.deg    = (area_s3 == '0);
		entry.in_tri = in0 && in1 && in2 && (area_s3 != '0);
		entry.neg1   = c1_s3[CROSS_W-1] ^ area_s3[CROSS_W-1];
		entry.neg2   = c2_s3[CROSS_W-1] ^ area_s3[CROSS_W-1];
		entry.num1   = mag(c1_s3);
		entry.num2   = mag(c2_s3);
		entry.den    = mag(area_s3);
	end

	assign push     = v_s3;
	assign inflight = 2'({1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3});
endmodule

### src/tbc_queue.sv
`timescale 1ns / 1ps
module tbc_queue import tbc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tbc_entry_t      wr_entry,
	input  logic            pop,
	output tbc_entry_t      head,
	output logic            not_empty,
	output logic [Q_AW:0]   count
);
	tbc_entry_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0] cnt_q;
	logic do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_entry;
	end

	assign head      = mem_q[rp_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;
endmodule

### src/tbc_back.sv
`timescale 1ns / 1ps
module tbc_back import tbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  tbc_entry_t               in_entry,
	output logic                     done,
	output logic signed [W_BITS-1:0] weight_zero,
	output logic signed [W_BITS-1:0] weight_one,
	output logic signed [W_BITS-1:0] weight_two,
	output logic                     inside_res,
	output logic                     degenerate
);
	localparam logic signed [W_BITS-1:0] WMAX = {1'b0, {(W_BITS-1){1'b1}}};
	localparam logic signed [W_BITS-1:0] WMIN = {1'b1, {(W_BITS-1){1'b0}}};

	div_stage_t st_s [QB+1];
	logic       vld_s [QB+1];
	div_stage_t st_d [QB];
	logic [DW-1:0] n1, n2, lim;
	logic signed [W_BITS-1:0] w1, w2;
	logic signed [W_BITS+1:0] w0;

	function automatic div_lane_t step(input div_lane_t l, input logic [DW-1:0] dsh,
		input int b);
		div_lane_t o;
		o = l;
		if (l.rem >= dsh) begin
			o.rem    = l.rem - dsh;
			o.quo[b] = 1'b1;
		end
		return o;
	endfunction

	function automatic logic signed [W_BITS-1:0] fin(input div_lane_t l);
		logic signed [W_BITS-1:0] q;
		q = W_BITS'({1'b0, l.quo});
		if (l.sat) return l.neg ? WMIN : WMAX;
		return l.neg ? -q : q;
	endfunction

	always_comb begin
		n1  = DW'(in_entry.num1) << FRAC_BITS;
		n2  = DW'(in_entry.num2) << FRAC_BITS;
		lim = DW'(in_entry.den) << QB;
		for (int j = 0; j < QB; j++) begin
			st_d[j]    = st_s[j];
			st_d[j].l1 = step(st_s[j].l1, DW'(st_s[j].den) << (QB-1-j), QB-1-j);
			st_d[j].l2 = step(st_s[j].l2, DW'(st_s[j].den) << (QB-1-j), QB-1-j);
		end
		w1 = fin(st_s[QB].l1);
		w2 = fin(st_s[QB].l2);
		w0 = (W_BITS+2)'(1 << FRAC_BITS) - (W_BITS+2)'(w1) - (W_BITS+2)'(w2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QB; j++) vld_s[j] <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int j = 0; j < QB; j++) vld_s[j+1] <= vld_s[j];
			done <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		st_s[0].l1.rem <= n1;
		st_s[0].l1.quo <= '0;
		st_s[0].l1.sat <= n1 >= lim;
		st_s[0].l1.neg <= in_entry.neg1;
		st_s[0].l2.rem <= n2;
		st_s[0].l2.quo <= '0;
		st_s[0].l2.sat <= n2 >= lim;
		st_s[0].l2.neg <= in_entry.neg2;
		st_s[0].den    <= in_entry.den;
		st_s[0].deg    <= in_entry.deg;
		st_s[0].in_tri <= in_entry.in_tri;
		for (int j = 0; j < QB; j++) st_s[j+1] <= st_d[j];
		degenerate <= st_s[QB].deg;
		inside_res <= st_s[QB].in_tri;
		if (st_s[QB].deg) begin
			weight_zero <= '0;
			weight_one  <= '0;
			weight_two  <= '0;
		end else begin
			weight_one  <= w1;
			weight_two  <= w2;
			if (w0 > (W_BITS+2)'(WMAX)) weight_zero <= WMAX;
			else if (w0 < (W_BITS+2)'(WMIN)) weight_zero <= WMIN;
			else weight_zero <= W_BITS'(w0);
		end
	end
endmodule

### src/triangle_barycentric_coords_top.sv
`timescale 1ns / 1ps
// Triangle barycentric weights, fixed point, one query per clock while busy is low.
// Input: drive the vertex and query ports and raise start; the beat is taken
// at a rising edge with start high and busy low.
// Output: done is high for one cycle with weight_zero/one/two (16 fraction
// bits, saturated), inside_res and degenerate valid in that same cycle.
// Pipeline: three front stages (edges, products, cross sums), one queue slot,
// then one divider setup stage, 23 restoring quotient stages for the two
// weight lanes and one output stage.
// Throughput: one beat per cycle while busy is low; the divider is fully pipelined.
// busy rises only when the queue plus the front stages could overfill it;
// the back end drains every cycle, so in practice busy stays low.
// The receiver cannot stall; results simply appear in order.
// Reset: arst_n clears the stage valids, queue pointers and done; beats in
// flight are dropped. No clearing pass.
`include "triangle_barycentric_coords_top_defines.svh"
module triangle_barycentric_coords_top import tbc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] vert0_x,
	input  logic signed [COORD_BITS-1:0] vert0_y,
	input  logic signed [COORD_BITS-1:0] vert1_x,
	input  logic signed [COORD_BITS-1:0] vert1_y,
	input  logic signed [COORD_BITS-1:0] vert2_x,
	input  logic signed [COORD_BITS-1:0] vert2_y,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	output logic                         done,
	output logic signed [W_BITS-1:0]     weight_zero,
	output logic signed [W_BITS-1:0]     weight_one,
	output logic signed [W_BITS-1:0]     weight_two,
	output logic                         inside_res,
	output logic                         degenerate
);
	logic accept, push, not_empty;
	logic [1:0] inflight;
	logic [Q_AW:0] count;
	tbc_entry_t entry, head;

	assign busy   = ((Q_AW+2)'(count) + (Q_AW+2)'(inflight)) >= (Q_AW+2)'(Q_DEPTH);
	assign accept = start && !busy;

	tbc_front u_front (
		.clk, .arst_n, .accept,
		.vert0_x, .vert0_y, .vert1_x, .vert1_y, .vert2_x, .vert2_y, .query_x, .query_y,
		.push, .entry, .inflight
	);

	tbc_queue u_queue (
		.clk, .arst_n, .push, .wr_entry(entry), .pop(not_empty),
		.head, .not_empty, .count
	);

	tbc_back u_back (
		.clk, .arst_n, .in_valid(not_empty), .in_entry(head),
		.done, .weight_zero, .weight_one, .weight_two, .inside_res, .degenerate
	);

	`TBC_ASSERT_IMP(a_deg_zero, done && degenerate,
		weight_zero == '0 && weight_one == '0 && weight_two == '0 && !inside_res,
		"degenerate result with nonzero weights or inside set")
	`TBC_ASSERT_IMP(a_inside_pos, done && inside_res,
		!weight_zero[W_BITS-1] && !weight_one[W_BITS-1] && !weight_two[W_BITS-1],
		"inside flag with a negative weight")
	`TBC_ASSERT_ALWAYS(a_queue_bound, count <= (Q_AW+1)'(Q_DEPTH),
		"queue count beyond its depth")
endmodule

### tb/triangle_barycentric_coords_top_tb.sv
`timescale 1ns / 1ps
module triangle_barycentric_coords_top_tb;
	import tbc_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int N_RANDOM        = 600;

	typedef struct {
		logic signed [COORD_BITS-1:0] c[8];
	} tri_beat_t;

	typedef struct {
		logic signed [W_BITS-1:0] w0, w1, w2;
		logic in_tri, deg;
	} bary_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [COORD_BITS-1:0] vin[8];
	logic signed [W_BITS-1:0] weight_zero, weight_one, weight_two;
	logic inside_res, degenerate;
	logic busy_q = 1'b0;

	tri_beat_t pending_tris[$];
	bary_t expected_bary[$];
	int n_errors = 0, n_sent = 0, n_checked = 0, n_deg = 0, n_inside = 0;
	int idle_cycles = 0;
	int burst_left = 0, gap_left = 0;
	bit stim_done = 0;

	always #6 clk = ~clk;

	triangle_barycentric_coords_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vert0_x(vin[0]), .vert0_y(vin[1]), .vert1_x(vin[2]), .vert1_y(vin[3]),
		.vert2_x(vin[4]), .vert2_y(vin[5]), .query_x(vin[6]), .query_y(vin[7]),
		.done(done), .weight_zero(weight_zero), .weight_one(weight_one),
		.weight_two(weight_two), .inside_res(inside_res), .degenerate(degenerate)
	);

	function automatic longint sat_weight(longint x);
		if (x > (longint'(1) <<< (W_BITS - 1)) - 1) return (longint'(1) <<< (W_BITS - 1)) - 1;
		if (x < -(longint'(1) <<< (W_BITS - 1))) return -(longint'(1) <<< (W_BITS - 1));
		return x;
	endfunction

	// cross * 2^FRAC / area, truncated toward zero, saturated
	function automatic longint weight_quot(longint num, longint den);
		longint un, ud, q, r, cap;
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		cap = longint'(1) <<< W_BITS;
		q = un / ud;
		r = un % ud;
		if (q > cap) q = cap;
		for (int i = 0; i < FRAC_BITS; i++) begin
			if (q >= cap) break;
			q = q <<< 1;
			r = r <<< 1;
			if (r >= ud) begin
				r -= ud;
				q++;
			end
		end
		if (q > cap) q = cap;
		return sat_weight(((num < 0) != (den < 0)) ? -q : q);
	endfunction

	function automatic bit same_sign(longint a, longint b);
		return (a > 0 && b > 0) || (a < 0 && b < 0);
	endfunction

	function automatic bary_t predict_bary(tri_beat_t t);
		bary_t b;
		longint e1x, e1y, e2x, e2y, dx, dy, area, c0, c1, c2, w1, w2;
		e1x = longint'(t.c[2]) - t.c[0];
		e1y = longint'(t.c[3]) - t.c[1];
		e2x = longint'(t.c[4]) - t.c[0];
		e2y = longint'(t.c[5]) - t.c[1];
		dx = longint'(t.c[6]) - t.c[0];
		dy = longint'(t.c[7]) - t.c[1];
		area = e1x * e2y - e1y * e2x;
		c1 = dx * e2y - dy * e2x;
		c2 = e1x * dy - e1y * dx;
		if (area == 0) begin
			b.w0 = '0;
			b.w1 = '0;
			b.w2 = '0;
			b.in_tri = 1'b0;
			b.deg = 1'b1;
			return b;
		end
		c0 = area - c1 - c2;
		w1 = weight_quot(c1, area);
		w2 = weight_quot(c2, area);
		b.w1 = W_BITS'(w1);
		b.w2 = W_BITS'(w2);
		b.w0 = W_BITS'(sat_weight((longint'(1) <<< FRAC_BITS) - w1 - w2));
		b.in_tri = same_sign(c0, area) && same_sign(c1, area) && same_sign(c2, area);
		b.deg = 1'b0;
		return b;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			n_checked, what, got, want);
		n_errors++;
	endtask

	function automatic tri_beat_t mk_tri(int a0, int a1, int a2, int a3,
			int a4, int a5, int a6, int a7);
		tri_beat_t t;
		t.c[0] = COORD_BITS'(a0); t.c[1] = COORD_BITS'(a1);
		t.c[2] = COORD_BITS'(a2); t.c[3] = COORD_BITS'(a3);
		t.c[4] = COORD_BITS'(a4); t.c[5] = COORD_BITS'(a5);
		t.c[6] = COORD_BITS'(a6); t.c[7] = COORD_BITS'(a7);
		return t;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rnd_coord(int span);
		case ($urandom_range(0, 5))
			0: return COORD_BITS'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return COORD_BITS'($signed($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	function automatic tri_beat_t rnd_tri();
		tri_beat_t t;
		int span, k;
		span = ($urandom_range(0, 3) == 0) ? 32767 : (1 << $urandom_range(2, 12));
		foreach (t.c[i]) t.c[i] = rnd_coord(span);
		k = $urandom_range(0, 9);
		if (k == 0) begin
			// collinear: v2 on the line through v0 and v1
			t.c[4] = COORD_BITS'(t.c[0] + 2 * (t.c[2] - t.c[0]));
			t.c[5] = COORD_BITS'(t.c[1] + 2 * (t.c[3] - t.c[1]));
		end else if (k == 1) begin
			t.c[6] = t.c[2 * $urandom_range(0, 2)];
			t.c[7] = t.c[6] == t.c[0] ? t.c[1] : (t.c[6] == t.c[2] ? t.c[3] : t.c[5]);
		end else if (k == 2) begin
			// point on edge v0-v1 midpoint
			t.c[6] = COORD_BITS'((longint'(t.c[0]) + t.c[2]) / 2);
			t.c[7] = COORD_BITS'((longint'(t.c[1]) + t.c[3]) / 2);
		end else if (k == 3) begin
			// centroid, often inside
			t.c[6] = COORD_BITS'((longint'(t.c[0]) + t.c[2] + t.c[4]) / 3);
			t.c[7] = COORD_BITS'((longint'(t.c[1]) + t.c[3] + t.c[5]) / 3);
		end else if (k == 4) begin
			t.c[2] = COORD_BITS'(int'(t.c[0]) + int'($urandom_range(0, 1)));
			t.c[3] = t.c[1];
			t.c[4] = t.c[0];
			t.c[5] = COORD_BITS'(int'(t.c[1]) + 1);
		end
		return t;
	endfunction

	// driver: bursts with random gaps, changes on falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(start && busy_q) ) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_tris.size() > 0) begin
					tri_beat_t t;
					t = pending_tris.pop_front();
					foreach (vin[i]) vin[i] <= t.c[i];
					start <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// capture busy as seen at the accepting edge; held beat stays put while busy
	always @(posedge clk) begin
		busy_q <= busy;
		if (arst_n) begin
			if (start && !busy) begin
				tri_beat_t t;
				foreach (vin[i]) t.c[i] = vin[i];
				expected_bary.push_back(predict_bary(t));
				n_sent++;
			end
			if (done) begin
				bary_t e;
				if (expected_bary.size() == 0) begin
					$display("result with no expectation pending");
					n_errors++;
				end else begin
					e = expected_bary.pop_front();
					if (weight_zero !== e.w0) report_mismatch("weight_zero", weight_zero, e.w0);
					if (weight_one !== e.w1) report_mismatch("weight_one", weight_one, e.w1);
					if (weight_two !== e.w2) report_mismatch("weight_two", weight_two, e.w2);
					if (inside_res !== e.in_tri)
						report_mismatch("inside_res", inside_res, e.in_tri);
					if (degenerate !== e.deg) report_mismatch("degenerate", degenerate, e.deg);
					n_deg += e.deg;
					n_inside += e.in_tri;
				end
				n_checked++;
			end
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("watchdog expired with %0d results outstanding", expected_bary.size());
			$display("triangle_barycentric_coords_top_tb: FAIL");
			$finish;
		end
	end

	initial begin
		foreach (vin[i]) vin[i] = '0;
		pending_tris.push_back(mk_tri(0, 0, 16, 0, 0, 16, 4, 4));
		pending_tris.push_back(mk_tri(0, 0, 0, 16, 16, 0, 4, 4));
		pending_tris.push_back(mk_tri(0, 0, 16, 0, 0, 16, 0, 0));
		pending_tris.push_back(mk_tri(0, 0, 16, 0, 0, 16, 8, 8));
		pending_tris.push_back(mk_tri(0, 0, 16, 0, 0, 16, 8, 0));
		pending_tris.push_back(mk_tri(0, 0, 16, 0, 0, 16, -5, 3));
		pending_tris.push_back(mk_tri(5, 5, 5, 5, 5, 5, 1, 2));
		pending_tris.push_back(mk_tri(0, 0, 3, 3, 7, 7, 1, 0));
		pending_tris.push_back(mk_tri(0, 0, 1, 0, 0, 1, 32767, 32767));
		pending_tris.push_back(mk_tri(0, 0, 1, 0, 0, 1, -32768, -32768));
		pending_tris.push_back(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767,
			32767, 32767));
		pending_tris.push_back(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767,
			-1, -1));
		pending_tris.push_back(mk_tri(32767, 32767, -32768, 32767, 32767, -32768,
			-32768, -32768));
		pending_tris.push_back(mk_tri(-32768, 32767, 32767, -32768, -32768, -32768,
			0, 0));
		pending_tris.push_back(mk_tri(0, 0, 3, 0, 0, 3, 1, 1));
		pending_tris.push_back(mk_tri(0, 0, 3, 0, 0, 7, 1, 1));
		pending_tris.push_back(mk_tri(-32768, -32768, -32767, -32768, -32768, -32767,
			32767, -32768));
		pending_tris.push_back(mk_tri(-1, -1, -1, -1, -1, -1, -1, -1));
		for (int i = 0; i < N_RANDOM; i++) pending_tris.push_back(rnd_tri());
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_tris.size() == 0);
		@(posedge clk);
		while (start && busy) @(posedge clk);
		wait (expected_bary.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d triangles, checked %0d results", n_sent, n_checked);
		$display("%0d degenerate, %0d strictly inside", n_deg, n_inside);
		if (n_errors == 0 && expected_bary.size() == 0) begin
			$display("triangle_barycentric_coords_top_tb: PASS");
		end else begin
			$display("triangle_barycentric_coords_top_tb: FAIL");
		end
		$finish;
	end
endmodule
